### hw/rtl/plg_pkg.sv
// Package for the power level governor: level codes, configuration
// register indexes, result tables and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package plg_pkg;

  // Level encoding: 0 long idle, 1 short idle, 2 keys active,
  // 3 pointer active, 4 charging.
  typedef logic [2:0] level_t;

  localparam int unsigned NumLevels = 5;
  localparam level_t LvlLongIdle      = 3'd0;
  localparam level_t LvlShortIdle     = 3'd1;
  localparam level_t LvlKeysActive    = 3'd2;
  localparam level_t LvlPointerActive = 3'd3;
  localparam level_t LvlCharging      = 3'd4;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned ScanW  = 15;
  localparam int unsigned LinkW  = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgDwellShortIdle    = 3'd0,
    CfgDwellKeysActive   = 3'd1,
    CfgDwellPointerActive = 3'd2,
    CfgDwellCharging     = 3'd3,
    CfgSleepLevelMask    = 3'd4
  } cfg_idx_e;

  localparam logic [TimeW-1:0] DwellShortIdleRst    = 32'd120000000;
  localparam logic [TimeW-1:0] DwellKeysActiveRst   = 32'd420000000;
  localparam logic [TimeW-1:0] DwellPointerActiveRst = 32'd120000000;
  localparam logic [TimeW-1:0] DwellChargingRst     = 32'd60000000;
  localparam logic [NumLevels-1:0] SleepLevelMaskRst = 5'd7;

  // Register bank contents; dwell[n] belongs to level n+1.
  typedef struct packed {
    logic [3:0][TimeW-1:0] dwell;
    logic [NumLevels-1:0]  sleep_mask;
  } cfg_t;

  // One request item.
  typedef struct packed {
    level_t           wanted_level;
    logic [TimeW-1:0] now_us;
    logic             charger_present;
  } req_t;

  // Governor state.
  typedef struct packed {
    level_t           level;
    logic [TimeW-1:0] last_change;
  } state_t;

  // One result item.
  typedef struct packed {
    level_t           level;
    logic             level_changed;
    logic [ScanW-1:0] scan_period_us;
    logic [LinkW-1:0] link_interval;
    logic             sleep_enable;
    logic             rapid_rise_wait;
  } res_t;

  // Scan interval per level: table value (25000, 5000, 2000) times 5/6.
  function automatic logic [ScanW-1:0] scan_period(input level_t lvl);
    logic [ScanW-1:0] val;
    unique case (lvl)
      LvlLongIdle:                                 val = 15'd20833;
      LvlShortIdle, LvlKeysActive, LvlPointerActive: val = 15'd4166;
      default:                                     val = 15'd1666;
    endcase
    return val;
  endfunction

  // Radio connection interval per level, in 1.25 ms units.
  function automatic logic [LinkW-1:0] link_interval(input level_t lvl);
    logic [LinkW-1:0] val;
    unique case (lvl)
      LvlLongIdle:   val = 10'd800;
      LvlShortIdle:  val = 10'd32;
      LvlKeysActive: val = 10'd20;
      default:       val = 10'd10;
    endcase
    return val;
  endfunction

endpackage

### hw/rtl/plg_if.sv
// Channel interfaces of the power level governor: request and result.
// Depends on plg_pkg.
`timescale 1ns / 1ps

interface plg_req_if;
  logic                     valid;
  logic                     ready;
  plg_pkg::level_t          wanted_level;
  logic [plg_pkg::TimeW-1:0] now_us;
  logic                     charger_present;

  modport source (output valid, wanted_level, now_us, charger_present, input ready);
  modport sink   (input valid, wanted_level, now_us, charger_present, output ready);
endinterface

interface plg_res_if;
  logic                     valid;
  logic                     ready;
  plg_pkg::level_t          level;
  logic                     level_changed;
  logic [plg_pkg::ScanW-1:0] scan_period_us;
  logic [plg_pkg::LinkW-1:0] link_interval;
  logic                     sleep_enable;
  logic                     rapid_rise_wait;

  modport source (output valid, level, level_changed, scan_period_us, link_interval,
                  sleep_enable, rapid_rise_wait, input ready);
  modport sink   (input valid, level, level_changed, scan_period_us, link_interval,
                  sleep_enable, rapid_rise_wait, output ready);
endinterface

### hw/rtl/plg_cfg_regs.sv
// Configuration register bank of the power level governor: four dwell
// times and the light-sleep level mask. Depends on plg_pkg.
`timescale 1ns / 1ps

module plg_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [plg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [plg_pkg::CfgDataW-1:0] cfg_wdata_i,
  output plg_pkg::cfg_t                cfg_o
);

  plg_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write; indexes beyond the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        plg_pkg::CfgDwellShortIdle:     cfg_d.dwell[0] = cfg_wdata_i;
        plg_pkg::CfgDwellKeysActive:    cfg_d.dwell[1] = cfg_wdata_i;
        plg_pkg::CfgDwellPointerActive: cfg_d.dwell[2] = cfg_wdata_i;
        plg_pkg::CfgDwellCharging:      cfg_d.dwell[3] = cfg_wdata_i;
        plg_pkg::CfgSleepLevelMask:
          cfg_d.sleep_mask = cfg_wdata_i[plg_pkg::NumLevels-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dwell[0]    <= plg_pkg::DwellShortIdleRst;
      cfg_q.dwell[1]    <= plg_pkg::DwellKeysActiveRst;
      cfg_q.dwell[2]    <= plg_pkg::DwellPointerActiveRst;
      cfg_q.dwell[3]    <= plg_pkg::DwellChargingRst;
      cfg_q.sleep_mask  <= plg_pkg::SleepLevelMaskRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/plg_step.sv
// Decision logic of the power level governor: from one registered request,
// the current state and the configuration, the next state and the result.
// Depends on plg_pkg.
`timescale 1ns / 1ps

module plg_step (
  input  plg_pkg::req_t   req_i,
  input  plg_pkg::state_t state_i,
  input  plg_pkg::cfg_t   cfg_i,
  output plg_pkg::state_t state_o,
  output plg_pkg::res_t   res_o
);

  plg_pkg::level_t             wanted;
  plg_pkg::level_t             cur;
  plg_pkg::level_t             target;
  plg_pkg::level_t             next_lvl;
  logic                        step_down;
  logic                        rise;
  logic                        timed_out;
  logic                        changed;
  logic [plg_pkg::TimeW-1:0]   elapsed;
  logic [plg_pkg::TimeW-1:0]   dwell;
  logic [1:0]                  dwell_sel;

  assign cur = state_i.level;

  // Saturate the wanted level to charging.
  assign wanted = (req_i.wanted_level > plg_pkg::LvlCharging) ? plg_pkg::LvlCharging
                                                              : req_i.wanted_level;

  // A lower request asks for one step down; charging forces the top level.
  assign step_down = !req_i.charger_present && (wanted < cur);
  always_comb begin
    if (req_i.charger_present) begin
      target = plg_pkg::LvlCharging;
    end else if (step_down) begin
      target = cur - 3'd1;
    end else begin
      target = wanted;
    end
  end

  // Dwell check only matters on a step down, where the time was not restamped.
  // A step down implies the current level is at least one.
  assign dwell_sel = 2'(cur - 3'd1);
  assign dwell     = cfg_i.dwell[dwell_sel];
  assign elapsed   = req_i.now_us - state_i.last_change;
  assign timed_out = step_down && (cur != plg_pkg::LvlLongIdle) && (elapsed > dwell);

  assign rise     = target > cur;
  assign changed  = rise || timed_out;
  assign next_lvl = changed ? target : cur;

  // Time is stamped on every request except a step down still waiting.
  assign state_o.level       = next_lvl;
  assign state_o.last_change = (step_down && !timed_out) ? state_i.last_change
                                                         : req_i.now_us;

  // Result fields for the level in force.
  assign res_o.level           = next_lvl;
  assign res_o.level_changed   = changed;
  assign res_o.scan_period_us  = plg_pkg::scan_period(next_lvl);
  assign res_o.link_interval   = plg_pkg::link_interval(next_lvl);
  assign res_o.sleep_enable    = cfg_i.sleep_mask[next_lvl];
  assign res_o.rapid_rise_wait = !req_i.charger_present &&
      ((cur == plg_pkg::LvlShortIdle && target == plg_pkg::LvlPointerActive) ||
       (cur == plg_pkg::LvlLongIdle && target >= plg_pkg::LvlKeysActive));

endmodule

### hw/rtl/power_level_governor.sv
// Top level of the power level governor: input register, decision logic,
// state and result register. Depends on plg_pkg, plg_if, plg_cfg_regs and
// plg_step.
//
// Usage: each request item on req_i carries the wanted level, a wrapping
// microsecond timestamp and the charger pin; each request gives exactly one
// result item on res_o with the level in force and its scan interval, radio
// interval, light-sleep enable and rapid-rise wait flag.
// The configuration port writes one register per cycle with cfg_we_i high:
// index 0..3 are the dwell times of levels 1..4, index 4 the sleep mask;
// other indexes are ignored. Write it only while no request is in flight.
// An accepted request is held in the input register, then decided and its result
// is held in the result register until the receiver takes it.
// Throughput: one item per cycle while the receiver keeps res_o.ready high;
// the level and timestamp registers are updated in the same cycle the
// decision is made, so back-to-back requests see each other's effect.
// Reset puts the governor in long idle with a zero timestamp and loads the
// default dwell times and sleep mask; both stages come up empty.
// When the receiver stalls, the result register holds its item and the
// input register keeps one more; req_i.ready drops once both are full.
`timescale 1ns / 1ps

module power_level_governor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  plg_req_if.sink                      req_i,
  plg_res_if.source                    res_o,
  input  logic                         cfg_we_i,
  input  logic [plg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [plg_pkg::CfgDataW-1:0] cfg_wdata_i
);

  plg_pkg::cfg_t   cfg;
  plg_pkg::req_t   in_q, in_d;
  logic            in_vld_q, in_vld_d;
  plg_pkg::state_t st_q, st_d, st_next;
  plg_pkg::res_t   out_q, out_d, step_res;
  logic            out_vld_q, out_vld_d;
  logic            out_adv;
  logic            in_rdy;

  plg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  plg_step u_step (
    .req_i   (in_q),
    .state_i (st_q),
    .cfg_i   (cfg),
    .state_o (st_next),
    .res_o   (step_res)
  );

  // Pipeline flow control.
  assign out_adv = !out_vld_q || res_o.ready;
  assign in_rdy  = !in_vld_q || out_adv;
  assign req_i.ready = in_rdy;

  // Input register loads a new item whenever it is free or draining.
  always_comb begin
    in_vld_d = in_rdy ? req_i.valid : in_vld_q;
    in_d     = in_q;
    if (in_rdy && req_i.valid) begin
      in_d.wanted_level    = req_i.wanted_level;
      in_d.now_us          = req_i.now_us;
      in_d.charger_present = req_i.charger_present;
    end
  end

  // State and result register advance together with the decided item.
  always_comb begin
    st_d      = st_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (out_adv) begin
      out_vld_d = in_vld_q;
      if (in_vld_q) begin
        st_d  = st_next;
        out_d = step_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q          <= 1'b0;
      out_vld_q         <= 1'b0;
      st_q.level        <= plg_pkg::LvlLongIdle;
      st_q.last_change  <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      st_q      <= st_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.level           = out_q.level;
  assign res_o.level_changed   = out_q.level_changed;
  assign res_o.scan_period_us  = out_q.scan_period_us;
  assign res_o.link_interval   = out_q.link_interval;
  assign res_o.sleep_enable    = out_q.sleep_enable;
  assign res_o.rapid_rise_wait = out_q.rapid_rise_wait;

endmodule

### dv/tb_top.sv
// Self-checking testbench for power_level_governor: drives request items,
// predicts every result item and compares each result field by field.
// Depends on plg_pkg, plg_if and the governor RTL.
`timescale 1ns / 1ps

module tb_top;
  import plg_pkg::*;

  localparam int unsigned SettleCycles = 6;
  localparam int unsigned ReportLimit  = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  plg_req_if req_if ();
  plg_res_if res_if ();

  power_level_governor uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted governor state and register bank.
  level_t           gov_level;
  logic [TimeW-1:0] gov_stamp;
  logic [TimeW-1:0] dwell_us [1:4];
  logic [NumLevels-1:0] sleep_mask;

  // Results still owed by the block, oldest first.
  res_t expected_res [$];
  res_t got_res;
  res_t want_res;

  int fail_cnt      = 0;
  int report_cnt    = 0;
  int tx_gap_max    = 0;
  int rx_gap_max    = 0;
  int rx_stall_left = 0;
  int rx_hold_left  = 0;
  logic [TimeW-1:0] clock_us = '0;

  // Dwell time of a level; long idle has none and never times out.
  function automatic logic [TimeW-1:0] dwell_of(input level_t lvl);
    case (lvl)
      LvlShortIdle:     return dwell_us[1];
      LvlKeysActive:    return dwell_us[2];
      LvlPointerActive: return dwell_us[3];
      LvlCharging:      return dwell_us[4];
      default:          return '0;
    endcase
  endfunction

  // Applies one request to the predicted state and returns its result.
  function automatic res_t advance_governor(input req_t rq);
    level_t           cur;
    level_t           tgt;
    level_t           wanted;
    logic [TimeW-1:0] elapsed;
    logic             rapid;
    logic             changed;
    int unsigned      scan_raw;
    res_t             r;
    cur     = gov_level;
    wanted  = rq.wanted_level;
    changed = 1'b0;
    if (wanted > LvlCharging) begin
      wanted = LvlCharging;
    end
    // Charging wins; a lower request only asks for one step down.
    if (rq.charger_present) begin
      tgt       = LvlCharging;
      gov_stamp = rq.now_us;
    end else if (wanted < cur) begin
      tgt = cur - 3'd1;
    end else begin
      tgt       = wanted;
      gov_stamp = rq.now_us;
    end
    rapid = !rq.charger_present &&
            ((cur == LvlShortIdle && tgt == LvlPointerActive) ||
             (cur == LvlLongIdle && tgt >= LvlKeysActive));
    elapsed = rq.now_us - gov_stamp;
    if (tgt > cur || (cur != LvlLongIdle && elapsed > dwell_of(cur))) begin
      cur       = tgt;
      gov_stamp = rq.now_us;
      changed   = 1'b1;
    end
    gov_level = cur;
    case (cur)
      LvlLongIdle: begin
        scan_raw        = 25000;
        r.link_interval = 10'd800;
      end
      LvlShortIdle: begin
        scan_raw        = 5000;
        r.link_interval = 10'd32;
      end
      LvlKeysActive: begin
        scan_raw        = 5000;
        r.link_interval = 10'd20;
      end
      LvlPointerActive: begin
        scan_raw        = 5000;
        r.link_interval = 10'd10;
      end
      default: begin
        scan_raw        = 2000;
        r.link_interval = 10'd10;
      end
    endcase
    r.level           = cur;
    r.level_changed   = changed;
    r.scan_period_us  = ScanW'(scan_raw * 5 / 6);
    r.sleep_enable    = sleep_mask[cur];
    r.rapid_rise_wait = rapid;
    return r;
  endfunction

  // Writes one register and mirrors it in the predicted bank.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgDwellShortIdle:     dwell_us[1] = data;
      CfgDwellKeysActive:    dwell_us[2] = data;
      CfgDwellPointerActive: dwell_us[3] = data;
      CfgDwellCharging:      dwell_us[4] = data;
      CfgSleepLevelMask:     sleep_mask  = data[NumLevels-1:0];
      default: ;
    endcase
  endtask

  // Offers one request item, waits for it to be taken, then idles for a random gap that may be none.
  task automatic send_request(input level_t wanted, input logic [TimeW-1:0] now,
                              input logic chg);
    req_t rq;
    int   gap;
    rq = '{wanted_level: wanted, now_us: now, charger_present: chg};
    req_if.valid           <= 1'b1;
    req_if.wanted_level    <= wanted;
    req_if.now_us          <= now;
    req_if.charger_present <= chg;
    do @(posedge clk_i); while (!req_if.ready);
    expected_res.push_back(advance_governor(rq));
    clock_us = now;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic pause_requests();
    req_if.valid <= 1'b0;
  endtask

  // Waits until every owed result has arrived and the pipeline is empty.
  task automatic wait_results_settled();
    while (expected_res.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Random request; timestamps mostly creep forward or land on the
  // dwell boundary of the current level so that step-downs happen.
  task automatic send_random_request();
    logic [TimeW-1:0] t;
    level_t           w;
    logic             chg;
    case ($urandom_range(0, 9))
      0:       t = $urandom();
      1, 2:    t = clock_us + $urandom_range(0, 20);
      3, 4, 5: t = gov_stamp + dwell_of(gov_level) + $urandom_range(0, 2) - 1;
      default: t = clock_us + $urandom_range(0, 1000000);
    endcase
    w   = ($urandom_range(0, 9) < 8) ? level_t'($urandom_range(0, 4))
                                     : level_t'($urandom_range(5, 7));
    chg = ($urandom_range(0, 9) == 0);
    send_request(w, t, chg);
  endtask

  function automatic logic [TimeW-1:0] pick_dwell();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(1, 50);
      3:       return $urandom();
      4:       return $urandom_range(100, 100000);
      default: return 1000;
    endcase
  endfunction

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 18;
    endcase
  endfunction

  // Default registers: rises, step-downs at the dwell boundary, saturation,
  // charging and timestamp wrap-around.
  task automatic test_directed_defaults();
    tx_gap_max = 5;
    rx_gap_max = 5;
    send_request(LvlLongIdle, 32'd0, 1'b0);
    send_request(LvlShortIdle, 32'd10, 1'b0);
    send_request(LvlPointerActive, 32'd20, 1'b0);
    send_request(LvlLongIdle, 32'd120000020, 1'b0);
    send_request(LvlLongIdle, 32'd120000021, 1'b0);
    send_request(level_t'(3'd7), 32'd400000001, 1'b0);
    send_request(LvlLongIdle, 32'd400000002, 1'b1);
    send_request(level_t'(3'd6), 32'd460000003, 1'b0);
    send_request(LvlLongIdle, 32'd520000004, 1'b0);
    send_request(LvlKeysActive, 32'hFFFF_FFF0, 1'b0);
    send_request(LvlKeysActive, 32'hFFFF_FFFF, 1'b0);
    send_request(LvlLongIdle, 32'd420000000, 1'b0);
    send_request(LvlLongIdle, 32'd540000000, 1'b0);
    send_request(LvlLongIdle, 32'd540000001, 1'b0);
    send_request(level_t'(3'd5), 32'hFFFF_FFFF, 1'b1);
    pause_requests();
    wait_results_settled();
  endtask

  // Zero dwell steps down on any elapsed time but none; unused register
  // indexes must leave the bank alone.
  task automatic test_zero_dwell();
    write_reg(CfgDwellShortIdle, '0);
    write_reg(CfgDwellKeysActive, '0);
    write_reg(CfgDwellPointerActive, '0);
    write_reg(CfgDwellCharging, '0);
    write_reg(CfgSleepLevelMask, '0);
    for (int k = int'(CfgSleepLevelMask) + 1; k < (1 << CfgIdxW); k++) begin
      write_reg(CfgIdxW'(k), $urandom());
    end
    tx_gap_max = 0;
    rx_gap_max = 0;
    send_request(LvlLongIdle, 32'hFFFF_FFFF, 1'b0);
    send_request(LvlLongIdle, 32'd0, 1'b0);
    send_request(LvlLongIdle, 32'd1, 1'b0);
    send_request(LvlLongIdle, 32'd2, 1'b0);
    send_request(LvlLongIdle, 32'd2, 1'b0);
    send_request(LvlLongIdle, 32'd3, 1'b0);
    send_request(LvlCharging, 32'd5, 1'b0);
    send_request(LvlShortIdle, 32'd6, 1'b1);
    send_request(LvlShortIdle, 32'd7, 1'b0);
    send_request(LvlShortIdle, 32'd8, 1'b0);
    send_request(LvlLongIdle, 32'd9, 1'b0);
    send_request(LvlPointerActive, 32'd10, 1'b0);
    pause_requests();
    wait_results_settled();
  endtask

  // Largest dwell: no step-down can ever happen; every level may sleep.
  task automatic test_max_dwell();
    write_reg(CfgDwellShortIdle, '1);
    write_reg(CfgDwellKeysActive, '1);
    write_reg(CfgDwellPointerActive, '1);
    write_reg(CfgDwellCharging, '1);
    write_reg(CfgSleepLevelMask, '1);
    tx_gap_max = 18;
    rx_gap_max = 18;
    repeat (40) send_random_request();
    pause_requests();
    wait_results_settled();
  endtask

  // Receiver holds off long enough for the block to fill and stall its
  // input; afterwards the sender stops until all results are back.
  task automatic test_result_backpressure();
    write_reg(CfgDwellShortIdle, $urandom_range(1, 50));
    write_reg(CfgDwellKeysActive, $urandom_range(1, 50));
    write_reg(CfgDwellPointerActive, $urandom_range(1, 50));
    write_reg(CfgDwellCharging, $urandom_range(1, 50));
    write_reg(CfgSleepLevelMask, $urandom_range(0, 31));
    tx_gap_max   = 0;
    rx_gap_max   = 2;
    rx_hold_left = 300;
    repeat (40) send_random_request();
    pause_requests();
    wait_results_settled();
    tx_gap_max = 6;
    repeat (20) send_random_request();
    pause_requests();
    wait_results_settled();
  endtask

  // Random phases, each under a fresh register setting and idling mix.
  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CfgDwellShortIdle, pick_dwell());
      write_reg(CfgDwellKeysActive, pick_dwell());
      write_reg(CfgDwellPointerActive, pick_dwell());
      write_reg(CfgDwellCharging, pick_dwell());
      write_reg(CfgSleepLevelMask, $urandom_range(0, 31));
      if (phase == 0) begin
        tx_gap_max = 0;
        rx_gap_max = 0;
      end else if (phase == 1) begin
        tx_gap_max = 18;
        rx_gap_max = 18;
      end else begin
        tx_gap_max = pick_gap_max();
        rx_gap_max = pick_gap_max();
      end
      repeat (305) send_random_request();
      pause_requests();
      wait_results_settled();
    end
  endtask

  // Result side: checks each accepted item, then decides the next ready.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got_res = '{level: res_if.level, level_changed: res_if.level_changed,
                    scan_period_us: res_if.scan_period_us,
                    link_interval: res_if.link_interval,
                    sleep_enable: res_if.sleep_enable,
                    rapid_rise_wait: res_if.rapid_rise_wait};
        if (expected_res.size() == 0) begin
          fail_cnt++;
          if (report_cnt < ReportLimit) begin
            $display("unexpected result item at %0t: level %0d", $realtime, got_res.level);
          end
          report_cnt++;
        end else begin
          want_res = expected_res.pop_front();
          if (got_res.level !== want_res.level ||
              got_res.level_changed !== want_res.level_changed ||
              got_res.scan_period_us !== want_res.scan_period_us ||
              got_res.link_interval !== want_res.link_interval ||
              got_res.sleep_enable !== want_res.sleep_enable ||
              got_res.rapid_rise_wait !== want_res.rapid_rise_wait) begin
            fail_cnt++;
            if (report_cnt < ReportLimit) begin
              $display("mismatch at %0t: expected lvl %0d chg %0b scan %0d link %0d slp %0b rr %0b",
                       $realtime, want_res.level, want_res.level_changed,
                       want_res.scan_period_us, want_res.link_interval,
                       want_res.sleep_enable, want_res.rapid_rise_wait);
              $display("               actual   lvl %0d chg %0b scan %0d link %0d slp %0b rr %0b",
                       got_res.level, got_res.level_changed, got_res.scan_period_us,
                       got_res.link_interval, got_res.sleep_enable, got_res.rapid_rise_wait);
            end
            report_cnt++;
          end
        end
        rx_stall_left = $urandom_range(0, rx_gap_max);
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        res_if.ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Main sequence.
  initial begin
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = '0;
    cfg_wdata_i            = '0;
    req_if.valid           = 1'b0;
    req_if.wanted_level    = LvlLongIdle;
    req_if.now_us          = '0;
    req_if.charger_present = 1'b0;
    gov_level              = LvlLongIdle;
    gov_stamp              = '0;
    dwell_us[1]            = DwellShortIdleRst;
    dwell_us[2]            = DwellKeysActiveRst;
    dwell_us[3]            = DwellPointerActiveRst;
    dwell_us[4]            = DwellChargingRst;
    sleep_mask             = SleepLevelMaskRst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_defaults();
    test_zero_dwell();
    test_max_dwell();
    test_result_backpressure();
    test_random_settings();
    pause_requests();
    wait_results_settled();
    if (fail_cnt == 0 && expected_res.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
